>>> design/mmcd_pkg.sv
// Shared types and constants for the min/max column decimator.
package mmcd_pkg;

  localparam int unsigned MAX_SAMPLES = 16384;

  localparam int unsigned CC_W    = 10;
  localparam int unsigned SC_W    = 15;
  localparam int unsigned XO_W    = 10;
  localparam int unsigned YB_W    = 10;
  localparam int unsigned YS_W    = 24;
  localparam int unsigned SMP_W   = 8;
  localparam int unsigned COLX_W  = 11;
  localparam int unsigned Y_W     = 16;
  localparam int unsigned ACC_W   = 26;
  localparam int unsigned IDX_W   = 26;
  localparam int unsigned CFGI_W  = 3;
  localparam int unsigned CFGD_W  = 24;

  localparam logic [SC_W-1:0] EFF_MAX = SC_W'(MAX_SAMPLES);

  localparam logic [CC_W-1:0] COLUMN_COUNT_RST = 10'd278;
  localparam logic [SC_W-1:0] SAMPLE_COUNT_RST = 15'd1024;
  localparam logic [XO_W-1:0] X_ORIGIN_RST     = 10'd0;
  localparam logic [YB_W-1:0] Y_BASE_RST       = 10'd200;
  localparam logic [YS_W-1:0] Y_SCALE_RST      = 24'd65536;

  localparam logic [SMP_W-1:0] MIN_INIT = 8'd255;
  localparam logic [SMP_W-1:0] MAX_INIT = 8'd0;

  typedef enum logic [CFGI_W-1:0] {
    REG_COLUMN_COUNT = 3'd0,
    REG_SAMPLE_COUNT = 3'd1,
    REG_X_ORIGIN     = 3'd2,
    REG_Y_BASE       = 3'd3,
    REG_Y_SCALE      = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [CC_W-1:0] column_count;
    logic [SC_W-1:0] sample_count;
    logic [XO_W-1:0] x_origin;
    logic [YB_W-1:0] y_base;
    logic [YS_W-1:0] y_scale;
  } cfg_t;

  // one finished column before scaling
  typedef struct packed {
    logic [COLX_W-1:0] column_x;
    logic [SMP_W-1:0]  col_min;
    logic [SMP_W-1:0]  col_max;
    logic              final_column;
  } col_t;

endpackage

>>> design/min_max_column_decimator.sv
// Column words pass through the input, column and output registers in turn.
// Throughput: one sample per cycle unless stalled. The boundary test compares
// 2*(column_count+1)*(sample index+1) with the boundary accumulator, combinationally.
// Reset: registers take their default values, no frame is armed, pipeline empties.
// Samples are ignored until a frame_start arrives with a valid configuration.
module min_max_column_decimator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mmcd_pkg::SMP_W-1:0]     sample,
  input  logic                           frame_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mmcd_pkg::COLX_W-1:0]    column_x,
  output logic signed [mmcd_pkg::Y_W-1:0] y_from_min,
  output logic signed [mmcd_pkg::Y_W-1:0] y_from_max,
  output logic                           final_column,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mmcd_pkg::CFGI_W-1:0]    cfg_index,
  input  logic [mmcd_pkg::CFGD_W-1:0]    cfg_data
);

  mmcd_pkg::cfg_t cfg;
  mmcd_pkg::col_t col;
  logic           col_valid;
  logic           col_stall;

  mmcd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mmcd_decim u_decim (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .frame_start (frame_start),
    .col_valid   (col_valid),
    .col_stall   (col_stall),
    .col         (col)
  );

  mmcd_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .col_valid    (col_valid),
    .col_stall    (col_stall),
    .col          (col),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .column_x     (column_x),
    .y_from_min   (y_from_min),
    .y_from_max   (y_from_max),
    .final_column (final_column)
  );

endmodule

>>> design/mmcd_cfg.sv
// Configuration register file for the min/max column decimator.
module mmcd_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mmcd_pkg::CFGI_W-1:0]  cfg_index,
  input  logic [mmcd_pkg::CFGD_W-1:0]  cfg_data,
  output mmcd_pkg::cfg_t               cfg
);

  mmcd_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.column_count <= mmcd_pkg::COLUMN_COUNT_RST;
      regs.sample_count <= mmcd_pkg::SAMPLE_COUNT_RST;
      regs.x_origin     <= mmcd_pkg::X_ORIGIN_RST;
      regs.y_base       <= mmcd_pkg::Y_BASE_RST;
      regs.y_scale      <= mmcd_pkg::Y_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mmcd_pkg::REG_COLUMN_COUNT: regs.column_count <= cfg_data[mmcd_pkg::CC_W-1:0];
        mmcd_pkg::REG_SAMPLE_COUNT: regs.sample_count <= cfg_data[mmcd_pkg::SC_W-1:0];
        mmcd_pkg::REG_X_ORIGIN:     regs.x_origin     <= cfg_data[mmcd_pkg::XO_W-1:0];
        mmcd_pkg::REG_Y_BASE:       regs.y_base       <= cfg_data[mmcd_pkg::YB_W-1:0];
        mmcd_pkg::REG_Y_SCALE:      regs.y_scale      <= cfg_data[mmcd_pkg::YS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/mmcd_decim.sv
// Input register, interval tracking and min/max per column, column register.
module mmcd_decim (
  input  logic                         clk,
  input  logic                         rst,
  input  mmcd_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mmcd_pkg::SMP_W-1:0]   sample,
  input  logic                         frame_start,
  output logic                         col_valid,
  input  logic                         col_stall,
  output mmcd_pkg::col_t               col
);

  // input register
  logic                        va;
  logic [mmcd_pkg::SMP_W-1:0]  a_sample;
  logic                        a_start;

  // frame state
  logic [mmcd_pkg::IDX_W-1:0]  sample_index;
  logic [mmcd_pkg::CC_W-1:0]   column_index;
  logic [mmcd_pkg::ACC_W-1:0]  boundary_accumulator;
  logic [mmcd_pkg::SMP_W-1:0]  running_min;
  logic [mmcd_pkg::SMP_W-1:0]  running_max;
  logic                        frame_active;
  // 2*(column_count+1) as it stood when the current interval end was set
  logic [mmcd_pkg::CC_W+1:0]   interval_div;

  logic                        vb;
  mmcd_pkg::col_t              b_col;

  logic b_free, a_free, a_fire;

  logic [mmcd_pkg::SC_W-1:0]   eff;
  logic [mmcd_pkg::CC_W:0]     dcnt;
  logic                        cfg_ok;
  logic [mmcd_pkg::SC_W:0]     two_n;
  logic [mmcd_pkg::CC_W+1:0]   two_d;

  logic [mmcd_pkg::ACC_W-1:0]  acc_cur;
  logic [mmcd_pkg::IDX_W-1:0]  si_cur;
  logic [mmcd_pkg::CC_W-1:0]   col_cur;
  logic [mmcd_pkg::SMP_W-1:0]  mn_cur, mx_cur, mn_new, mx_new;
  logic [mmcd_pkg::CC_W+1:0]   div_cur;
  logic                        act_cur, run;

  logic [mmcd_pkg::IDX_W:0]    si_inc;
  logic [38:0]                 prod, prod_hi, acc_x;
  logic                        hit;
  logic [mmcd_pkg::CC_W:0]     col_inc;

  logic [mmcd_pkg::IDX_W-1:0]  sample_index_next;
  logic [mmcd_pkg::CC_W-1:0]   column_index_next;
  logic [mmcd_pkg::ACC_W-1:0]  boundary_accumulator_next;
  logic [mmcd_pkg::SMP_W-1:0]  running_min_next, running_max_next;
  logic                        frame_active_next;
  logic [mmcd_pkg::CC_W+1:0]   interval_div_next;
  mmcd_pkg::col_t              b_col_next;

  assign b_free   = !vb || !col_stall;
  assign a_free   = !va || b_free;
  assign a_fire   = va && b_free;
  assign in_stall = !a_free;

  assign col_valid = vb;
  assign col       = b_col;

  always_comb begin
    eff    = (cfg.sample_count < mmcd_pkg::EFF_MAX) ? cfg.sample_count : mmcd_pkg::EFF_MAX;
    dcnt   = {1'b0, cfg.column_count} + 11'd1;
    cfg_ok = (cfg.column_count != '0) && (eff >= {4'b0, dcnt});
    two_n  = {eff, 1'b0};
    two_d  = {dcnt, 1'b0};

    if (a_start) begin
      acc_cur = {10'b0, two_n} + {15'b0, dcnt};
      si_cur  = '0;
      col_cur = '0;
      mn_cur  = mmcd_pkg::MIN_INIT;
      mx_cur  = mmcd_pkg::MAX_INIT;
      div_cur = two_d;
      act_cur = cfg_ok;
    end else begin
      acc_cur = boundary_accumulator;
      si_cur  = sample_index;
      col_cur = column_index;
      mn_cur  = running_min;
      mx_cur  = running_max;
      div_cur = interval_div;
      act_cur = frame_active;
    end
    run = act_cur && cfg_ok;

    mn_new = (a_sample < mn_cur) ? a_sample : mn_cur;
    mx_new = (a_sample > mx_cur) ? a_sample : mx_cur;

    // last sample of an interval: 2D*(i+1) <= acc < 2D*(i+2), or acc < 2D at index 0
    si_inc  = {1'b0, si_cur} + 27'd1;
    prod    = {27'b0, div_cur} * {12'b0, si_inc};
    prod_hi = prod + {27'b0, div_cur};
    acc_x   = {13'b0, acc_cur};
    hit     = ((acc_x >= prod) && (acc_x < prod_hi)) ||
              ((acc_x < {27'b0, div_cur}) && (si_cur == '0));

    col_inc = {1'b0, col_cur} + 11'd1;

    sample_index_next         = si_cur;
    column_index_next         = col_cur;
    boundary_accumulator_next = acc_cur;
    running_min_next          = mn_cur;
    running_max_next          = mx_cur;
    frame_active_next         = act_cur;
    interval_div_next         = div_cur;

    b_col_next.column_x     = {1'b0, cfg.x_origin} + {1'b0, col_cur};
    b_col_next.col_min      = mn_new;
    b_col_next.col_max      = mx_new;
    b_col_next.final_column = (col_inc == {1'b0, cfg.column_count});

    if (run) begin
      // saturate rather than wrap; a wrapped index could fake a boundary
      sample_index_next = (si_cur == '1) ? si_cur : si_inc[mmcd_pkg::IDX_W-1:0];
      if (hit) begin
        column_index_next         = col_inc[mmcd_pkg::CC_W-1:0];
        boundary_accumulator_next = acc_cur + {10'b0, two_n};
        running_min_next          = mmcd_pkg::MIN_INIT;
        running_max_next          = mmcd_pkg::MAX_INIT;
        frame_active_next         = act_cur && (col_inc < {1'b0, cfg.column_count});
        interval_div_next         = two_d;
      end else begin
        running_min_next = mn_new;
        running_max_next = mx_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (a_free) begin
      va <= in_valid;
    end
    if (in_valid && a_free) begin
      a_sample <= sample;
      a_start  <= frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index         <= '0;
      column_index         <= '0;
      boundary_accumulator <= '0;
      running_min          <= mmcd_pkg::MIN_INIT;
      running_max          <= mmcd_pkg::MAX_INIT;
      frame_active         <= 1'b0;
      interval_div         <= '0;
    end else if (a_fire) begin
      sample_index         <= sample_index_next;
      column_index         <= column_index_next;
      boundary_accumulator <= boundary_accumulator_next;
      running_min          <= running_min_next;
      running_max          <= running_max_next;
      frame_active         <= frame_active_next;
      interval_div         <= interval_div_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (b_free) begin
      vb <= a_fire && run && hit;
    end
    if (a_fire && run && hit) begin
      b_col <= b_col_next;
    end
  end

endmodule

>>> design/mmcd_scale.sv
// Output register: scales column min/max to y coordinates with saturation.
module mmcd_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  mmcd_pkg::cfg_t                cfg,
  input  logic                          col_valid,
  output logic                          col_stall,
  input  mmcd_pkg::col_t                col,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mmcd_pkg::COLX_W-1:0]   column_x,
  output logic signed [mmcd_pkg::Y_W-1:0] y_from_min,
  output logic signed [mmcd_pkg::Y_W-1:0] y_from_max,
  output logic                          final_column
);

  logic c_free;
  logic [32:0] prod_min, prod_max;
  logic signed [17:0] v_min, v_max;
  logic signed [mmcd_pkg::Y_W-1:0] y_min_next, y_max_next;

  assign c_free    = !out_valid || !out_stall;
  assign col_stall = !c_free;

  always_comb begin
    // round half up: (code*scale + 2^15) >> 16
    prod_min = {1'b0, {24'b0, col.col_min} * {8'b0, cfg.y_scale}} + 33'h8000;
    prod_max = {1'b0, {24'b0, col.col_max} * {8'b0, cfg.y_scale}} + 33'h8000;
    v_min    = $signed({8'b0, cfg.y_base}) - $signed({1'b0, prod_min[32:16]});
    v_max    = $signed({8'b0, cfg.y_base}) - $signed({1'b0, prod_max[32:16]});
    y_min_next = (v_min < -18'sd32768) ? 16'sh8000 : v_min[mmcd_pkg::Y_W-1:0];
    y_max_next = (v_max < -18'sd32768) ? 16'sh8000 : v_max[mmcd_pkg::Y_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_free) begin
      out_valid <= col_valid;
    end
    if (c_free && col_valid) begin
      column_x     <= col.column_x;
      y_from_min   <= y_min_next;
      y_from_max   <= y_max_next;
      final_column <= col.final_column;
    end
  end

endmodule
